### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the checker file arlp_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is low
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset too
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/arlp_pkg.sv
// ----------------------------------------------------------------------------
// arlp_pkg
// Types, codes and helpers shared by the range list parser modules.
// ----------------------------------------------------------------------------
package arlp_pkg;

  typedef enum logic [3:0] {
    PH_ID, PH_CHI, PH_CLO, PH_FLAG,
    PH_MIN0, PH_MIN1, PH_MIN2,
    PH_MAX0, PH_MAX1, PH_MAX2,
    PH_DONE, PH_EMPTY
  } phase_t;

  localparam logic [1:0] ST_RANGE = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0]  packet_id;
    logic [23:0] range_min;
    logic [23:0] range_max;
    logic        last_range;
    logic [1:0]  status;
  } arlp_result_t;

  // add one byte to a 24-bit number; k is the byte's position in arrival order
  function automatic logic [23:0] triad_add(input logic [23:0] acc, input logic [7:0] b,
                                            input logic [1:0] k, input logic be);
    logic [23:0] r;
    if (be) begin
      r = {acc[15:0], b};
    end else begin
      r = acc | ({16'h0000, b} << {k, 3'b000});
    end
    return r;
  endfunction

endpackage

### hw/rtl/arlp_queue.sv
// ----------------------------------------------------------------------------
// arlp_queue
// Short result queue between the parser front and the output stage.
// ----------------------------------------------------------------------------
module arlp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  arlp_pkg::arlp_result_t push_data,
  input  logic                  pop,
  output logic                  full,
  output logic                  valid,
  output arlp_pkg::arlp_result_t head
);
  import arlp_pkg::*;

  arlp_result_t      mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

### hw/rtl/arlp_front.sv
// ----------------------------------------------------------------------------
// arlp_front
// Byte parser: tracks the packet phase and builds one result per range or end.
// ----------------------------------------------------------------------------
module arlp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  triad_be,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_packet,
  output logic                  push,
  output arlp_pkg::arlp_result_t push_data
);
  import arlp_pkg::*;

  phase_t      phase_r, phase_nxt, phase_step;
  logic [15:0] ranges_r, ranges_nxt;
  logic        single_r, single_nxt;
  logic [23:0] min_r, min_nxt;
  logic [23:0] max_r, max_nxt;
  logic [7:0]  id_r, id_nxt;
  logic        done;
  logic        last;

  assign last = (ranges_r == 16'd1);
  assign done = ((phase_r == PH_MIN2) && single_r) || (phase_r == PH_MAX2);

  always_comb begin
    phase_step = phase_r;
    case (phase_r)
      PH_ID:    phase_step = PH_CHI;
      PH_CHI:   phase_step = PH_CLO;
      PH_CLO:   phase_step = ({ranges_r[15:8], data_byte} != 16'd0) ? PH_FLAG : PH_EMPTY;
      PH_FLAG:  phase_step = PH_MIN0;
      PH_MIN0:  phase_step = PH_MIN1;
      PH_MIN1:  phase_step = PH_MIN2;
      PH_MIN2:  phase_step = single_r ? (last ? PH_DONE : PH_FLAG) : PH_MAX0;
      PH_MAX0:  phase_step = PH_MAX1;
      PH_MAX1:  phase_step = PH_MAX2;
      PH_MAX2:  phase_step = last ? PH_DONE : PH_FLAG;
      PH_DONE:  phase_step = PH_DONE;
      PH_EMPTY: phase_step = PH_EMPTY;
      default:  phase_step = PH_CHI;
    endcase
    phase_nxt = end_of_packet ? PH_ID : phase_step;
  end

  always_comb begin
    ranges_nxt = ranges_r;
    single_nxt = single_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    id_nxt     = id_r;
    case (phase_r)
      PH_CHI:  ranges_nxt = {data_byte, 8'h00};
      PH_CLO:  ranges_nxt = {ranges_r[15:8], data_byte};
      PH_FLAG: begin
        single_nxt = (data_byte != 8'h00);
        min_nxt    = '0;
        max_nxt    = '0;
      end
      PH_MIN0: min_nxt = triad_add(min_r, data_byte, 2'd0, triad_be);
      PH_MIN1: min_nxt = triad_add(min_r, data_byte, 2'd1, triad_be);
      PH_MIN2: begin
        min_nxt = triad_add(min_r, data_byte, 2'd2, triad_be);
        if (single_r) begin
          max_nxt = min_nxt;
        end
      end
      PH_MAX0: max_nxt = triad_add(max_r, data_byte, 2'd0, triad_be);
      PH_MAX1: max_nxt = triad_add(max_r, data_byte, 2'd1, triad_be);
      PH_MAX2: max_nxt = triad_add(max_r, data_byte, 2'd2, triad_be);
      PH_DONE, PH_EMPTY: ;
      default: id_nxt = data_byte;
    endcase
    if (done) begin
      ranges_nxt = ranges_r - 16'd1;
    end
  end

  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if (done) begin
      push                 = accept;
      push_data.packet_id  = id_r;
      push_data.range_min  = min_nxt;
      push_data.range_max  = max_nxt;
      push_data.last_range = last;
      push_data.status     = (end_of_packet && !last) ? ST_TRUNC : ST_RANGE;
    end else if (end_of_packet && (phase_step != PH_DONE)) begin
      push                = accept;
      push_data.packet_id = id_nxt;
      push_data.status    = (phase_step == PH_EMPTY) ? ST_EMPTY : ST_TRUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_ID;
      ranges_r <= '0;
      single_r <= 1'b0;
      min_r    <= '0;
      max_r    <= '0;
      id_r     <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      if (end_of_packet) begin
        ranges_r <= '0;
        single_r <= 1'b0;
        min_r    <= '0;
        max_r    <= '0;
      end else begin
        ranges_r <= ranges_nxt;
        single_r <= single_nxt;
        min_r    <= min_nxt;
        max_r    <= max_nxt;
      end
    end
  end

endmodule

### hw/rtl/arlp_back.sv
// ----------------------------------------------------------------------------
// arlp_back
// Output stage: takes results from the queue and holds them on the stream.
// ----------------------------------------------------------------------------
module arlp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  arlp_pkg::arlp_result_t q_head,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [55:0]           out_tdata,
  output logic                  out_tlast,
  output logic [1:0]            out_tuser
);
  import arlp_pkg::*;

  logic         valid_r;
  arlp_result_t rec_r;

  assign q_pop = q_valid && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_tready) begin
      valid_r <= q_valid;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {rec_r.range_max, rec_r.range_min, rec_r.packet_id};
  assign out_tlast  = rec_r.last_range;
  assign out_tuser  = rec_r.status;

endmodule

### hw/rtl/ack_range_list_parser_unit.sv
// ----------------------------------------------------------------------------
// ack_range_list_parser_unit: acknowledgement range list parser, one byte a cycle while the queue is not full.
// Path: a result passes through the result queue and then the output register before it is on out_tvalid.
// Throughput: one byte each cycle while the result queue is not full; in_tready drops when it is full.
// Reset: synchronous rst_n clears phase, counts, queue, output and register.
// ----------------------------------------------------------------------------
module ack_range_list_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] packet_id, [31:8] range_min, [55:32] range_max
  output logic        out_tlast,
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import arlp_pkg::*;

  logic         triad_be_r;
  logic         accept;
  logic         push;
  arlp_result_t push_data;
  logic         q_full;
  logic         q_valid;
  logic         q_pop;
  arlp_result_t q_head;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {31'h0, triad_be_r} : {31'h0, triad_be_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      triad_be_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      triad_be_r <= cfg_pwdata[0];
    end
  end

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  arlp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .triad_be      (triad_be_r),
    .accept        (accept),
    .data_byte     (in_tdata),
    .end_of_packet (in_tlast),
    .push          (push),
    .push_data     (push_data)
  );

  arlp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  arlp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### hw/rtl/arlp_checker.sv
// ----------------------------------------------------------------------------
// arlp_checker
// Port-level checks on the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arlp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);
  import arlp_pkg::*;

  `ASSERT_CLKD(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "item dropped while stalled")
  `ASSERT_CLKD(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "item changed while stalled")
  `ASSERT_CLKD(a_last_ok, clk, rst_n, out_tvalid && out_tlast |-> out_tuser == ST_RANGE, "last range with bad status")
  `ASSERT_CLKD(a_empty_clr, clk, rst_n, out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[55:8] == 48'h0 && !out_tlast, "empty packet item carries a range")
  `ASSERT_CLK(a_rst_idle, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind ack_range_list_parser_unit arlp_checker u_arlp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: acknowledgement range list parser testbench
// Streams hand-made and random ack packets into the parser under random idle
// and stall patterns on both sides, predicts every range, truncation and
// empty-packet report in a scoreboard, and checks each result as it leaves.
// ----------------------------------------------------------------------------
module tb;
  import arlp_pkg::*;

  class range_scoreboard;
    arlp_result_t pending_ranges[$];
    int           mismatches;
    logic         order_be;
    phase_t       phase;
    logic [15:0]  ranges_left;
    logic         single;
    logic [23:0]  min_acc;
    logic [23:0]  max_acc;
    logic [7:0]   pkt_id;

    function new();
      mismatches  = 0;
      order_be    = 1'b0;
      phase       = PH_ID;
      ranges_left = '0;
      single      = 1'b0;
      min_acc     = '0;
      max_acc     = '0;
      pkt_id      = '0;
    endfunction

    function void set_order(input logic be);
      order_be = be;
    endfunction

    function int pending();
      return pending_ranges.size();
    endfunction

    function void record(input arlp_result_t r);
      pending_ranges.insert(pending_ranges.size(), r);
    endfunction

    function logic [23:0] merge_byte(input logic [23:0] acc, input logic [7:0] b,
                                     input int k);
      if (order_be) begin
        return {acc[15:0], b};
      end
      return acc | (24'(b) << (8 * k));
    endfunction

    function void note_byte(input logic [7:0] b, input logic eop);
      arlp_result_t r;
      logic         done;
      logic         last;
      done = 1'b0;
      last = 1'b0;
      case (phase)
        PH_CHI: begin
          ranges_left = {b, 8'h00};
          phase = PH_CLO;
        end
        PH_CLO: begin
          ranges_left = {ranges_left[15:8], b};
          phase = (ranges_left != 0) ? PH_FLAG : PH_EMPTY;
        end
        PH_FLAG: begin
          single  = (b != 0);
          min_acc = '0;
          max_acc = '0;
          phase   = PH_MIN0;
        end
        PH_MIN0, PH_MIN1, PH_MIN2: begin
          min_acc = merge_byte(min_acc, b, int'(phase) - int'(PH_MIN0));
          if (phase != PH_MIN2) begin
            phase = phase_t'(phase + 1);
          end else if (single) begin
            max_acc = min_acc;
            done = 1'b1;
          end else begin
            phase = PH_MAX0;
          end
        end
        PH_MAX0, PH_MAX1, PH_MAX2: begin
          max_acc = merge_byte(max_acc, b, int'(phase) - int'(PH_MAX0));
          if (phase != PH_MAX2) begin
            phase = phase_t'(phase + 1);
          end else begin
            done = 1'b1;
          end
        end
        PH_DONE, PH_EMPTY: begin
        end
        default: begin
          pkt_id = b;
          phase = PH_CHI;
        end
      endcase

      if (done) begin
        last = (ranges_left == 16'd1);
        ranges_left = ranges_left - 16'd1;
        phase = last ? PH_DONE : PH_FLAG;
        r.packet_id  = pkt_id;
        r.range_min  = min_acc;
        r.range_max  = max_acc;
        r.last_range = last;
        r.status     = (eop && !last) ? ST_TRUNC : ST_RANGE;
        record(r);
      end else if (eop && phase != PH_DONE) begin
        r.packet_id  = pkt_id;
        r.range_min  = '0;
        r.range_max  = '0;
        r.last_range = 1'b0;
        r.status     = (phase == PH_EMPTY) ? ST_EMPTY : ST_TRUNC;
        record(r);
      end

      if (eop) begin
        phase       = PH_ID;
        ranges_left = '0;
        single      = 1'b0;
        min_acc     = '0;
        max_acc     = '0;
      end
    endfunction

    function void compare(input string field, input logic [23:0] want,
                          input logic [23:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(input arlp_result_t got);
      arlp_result_t want;
      if (pending_ranges.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_ranges.pop_front();
      compare("packet_id", 24'(want.packet_id), 24'(got.packet_id));
      compare("range_min", want.range_min, got.range_min);
      compare("range_max", want.range_max, got.range_max);
      compare("last_range", 24'(want.last_range), 24'(got.last_range));
      compare("status", 24'(want.status), 24'(got.status));
    endfunction
  endclass

  localparam logic [1:0] ADDR_TRIAD_BE = 2'd0;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PHASE_ITEMS   = 350;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  range_scoreboard sb;
  logic [8:0]      pkt[$];
  bit              hold_req;
  bit              press;
  bit              rx_eager;
  int              idle_cycles;

  logic [8:0] directed_seq[$] = '{
    9'h1FF,
    9'h000, 9'h000, 9'h100,
    9'h0A5, 9'h000, 9'h001, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
    9'h05A, 9'h000, 9'h002, 9'h000, 9'h000, 9'h000, 9'h000, 9'h0FF, 9'h0FF, 9'h1FF,
    9'h012, 9'h180
  };

  ack_range_list_parser_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_byte(in_tdata, in_tlast);
    end
  end

  always @(posedge clk) begin
    arlp_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.packet_id  = out_tdata[7:0];
      got.range_min  = out_tdata[31:8];
      got.range_max  = out_tdata[55:32];
      got.last_range = out_tlast;
      got.status     = out_tuser;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: random stalls, eager stretches, one long hold-off on request
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = rx_eager ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if ($urandom_range(0, 15) == 0) begin
        rx_eager = !rx_eager;
      end
    end
  end

  function automatic int pick_wait();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [23:0] pick_seq();
    case ($urandom_range(0, 9))
      0: begin
        return 24'h000000;
      end
      1: begin
        return 24'hFFFFFF;
      end
      default: begin
        return 24'($urandom);
      end
    endcase
  endfunction

  task automatic send_byte(input logic [8:0] item, input bit quiet);
    int gap;
    gap = quiet ? 0 : pick_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item[7:0];
    in_tlast  <= item[8];
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_TRIAD_BE) begin
      sb.set_order(value[0]);
    end
  endtask

  task automatic settle();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_byte(input logic [8:0] item);
    pkt.insert(pkt.size(), item);
  endtask

  task automatic push_triad(input logic [23:0] v);
    add_byte({1'b0, v[7:0]});
    add_byte({1'b0, v[15:8]});
    add_byte({1'b0, v[23:16]});
  endtask

  task automatic build_ack(input bit cut);
    int         count;
    int         ranges;
    int         cut_at;
    logic [7:0] flag;
    pkt.delete();
    add_byte({1'b0, 8'($urandom)});
    if (cut && $urandom_range(0, 1) == 1) begin
      count = $urandom_range(0, 65535);
    end else begin
      count = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 4);
    end
    add_byte({1'b0, 8'(count >> 8)});
    add_byte({1'b0, 8'(count)});
    ranges = (count > 4) ? 4 : count;
    repeat (ranges) begin
      flag = ($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom_range(1, 255));
      add_byte({1'b0, flag});
      push_triad(pick_seq());
      if (flag == 8'h00) begin
        push_triad(pick_seq());
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) add_byte({1'b0, 8'($urandom)});
    end
    if (cut) begin
      cut_at = $urandom_range(0, pkt.size() - 1);
      while (pkt.size() > cut_at + 1) void'(pkt.pop_back());
    end
    pkt[pkt.size() - 1][8] = 1'b1;
  endtask

  task automatic build_noise();
    pkt.delete();
    repeat ($urandom_range(1, 12)) begin
      add_byte({($urandom_range(0, 5) == 0), 8'($urandom)});
    end
    pkt[pkt.size() - 1][8] = 1'b1;
  endtask

  task automatic run_random(input int target);
    int sent;
    int pick;
    bit quiet;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        build_ack(1'b0);
      end else if (pick < 17) begin
        build_ack(1'b1);
      end else begin
        build_noise();
      end
      quiet = press || ($urandom_range(0, 3) == 0);
      foreach (pkt[i]) send_byte(pkt[i], quiet);
      sent += pkt.size();
      if (sent > 60) begin
        press = 1'b0;
      end
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    sb          = new();
    hold_req    = 1'b0;
    press       = 1'b0;
    rx_eager    = 1'b0;
    idle_cycles = 0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(ADDR_TRIAD_BE, 32'd0);
    foreach (directed_seq[i]) send_byte(directed_seq[i], 1'b0);
    in_tvalid <= 1'b0;
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(ADDR_TRIAD_BE, (ph % 2 == 0) ? 32'd1 : 32'd0);
      if (ph == 1) begin
        hold_req = 1'b1;
        press = 1'b1;
      end
      run_random(PHASE_ITEMS);
      settle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
